>>> rtl/bss_pkg.sv
// Shared types and constants of the beam search score selector.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package bss_pkg;

  // Default sizing of the score store and of the score word.
  localparam int MaxBeamsDef  = 16;
  localparam int ScoreBitsDef = 32;

  // No more than this many scores are ever kept or emitted per run.
  localparam int EmitLimit = 16;

  // Field widths of the input and result items.
  localparam int LogProbW   = 32;
  localparam int BeamIndexW = 4;
  localparam int FinalW     = 32;
  localparam int RankW      = 4;

  // Configuration register file.
  localparam int NumBeamsW  = 5;
  localparam int ApbDataW   = 32;
  localparam int ApbAddrW   = 3;
  localparam int RegIdxLsb  = 2;
  localparam logic [NumBeamsW-1:0] NumBeamsRst = 5'd4;
  localparam logic RegNumBeams = 1'b0;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_INSERT,
    ST_COMMIT,
    ST_EMIT
  } bss_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic calc;
    logic insert;
    logic commit;
    logic emit;
    logic clear;
  } bss_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic end_step;
    logic end_seq;
    logic out_free;
    logic emit_last;
  } bss_stat_t;

endpackage

>>> rtl/bss_if.sv
// Valid/ready channel interfaces for the input items and the result items.
// Depends on bss_pkg for the field widths.
`timescale 1ns / 1ps

interface bss_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bss_pkg::LogProbW-1:0]  log_prob;
  logic [bss_pkg::BeamIndexW-1:0]       beam_index;
  logic                                 last_in_step;
  logic                                 last_in_sequence;

  modport source (output valid, log_prob, beam_index, last_in_step, last_in_sequence,
                  input ready);
  modport sink (input valid, log_prob, beam_index, last_in_step, last_in_sequence,
                output ready);
endinterface

interface bss_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [bss_pkg::FinalW-1:0]   final_score;
  logic [bss_pkg::RankW-1:0]           score_rank;
  logic                                last_score;

  modport source (output valid, final_score, score_rank, last_score, input ready);
  modport sink (input valid, final_score, score_rank, last_score, output ready);
endinterface

>>> rtl/bss_ctrl.sv
// Controller state machine: sequences accept, add, insert, commit and emit.
// Depends on bss_pkg for the state enum and the command and status structs.
`timescale 1ns / 1ps

module bss_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bss_pkg::bss_stat_t stat_i,
  output bss_pkg::bss_cmd_t  cmd_o
);

  bss_pkg::bss_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bss_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      bss_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = bss_pkg::ST_ADD;
      end
      bss_pkg::ST_ADD: begin
        state_d = bss_pkg::ST_INSERT;
      end
      bss_pkg::ST_INSERT: begin
        if (stat_i.end_step || stat_i.end_seq) state_d = bss_pkg::ST_COMMIT;
        else state_d = bss_pkg::ST_IDLE;
      end
      bss_pkg::ST_COMMIT: begin
        if (stat_i.end_seq) state_d = bss_pkg::ST_EMIT;
        else state_d = bss_pkg::ST_IDLE;
      end
      bss_pkg::ST_EMIT: begin
        if (stat_i.out_free && stat_i.emit_last) state_d = bss_pkg::ST_IDLE;
      end
      default: begin
        state_d = bss_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs: handshake and datapath commands.
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      bss_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      bss_pkg::ST_ADD: begin
        cmd_o.calc = 1'b1;
      end
      bss_pkg::ST_INSERT: begin
        cmd_o.insert = 1'b1;
      end
      bss_pkg::ST_COMMIT: begin
        cmd_o.commit = 1'b1;
      end
      bss_pkg::ST_EMIT: begin
        cmd_o.emit  = stat_i.out_free;
        cmd_o.clear = stat_i.out_free && stat_i.emit_last;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/bss_datapath.sv
// Datapath: beam score store, saturating adder, sorted candidate chain and
// result register. Depends on bss_pkg for widths, commands and status.
`timescale 1ns / 1ps

module bss_datapath #(
  parameter int MAX_BEAMS  = bss_pkg::MaxBeamsDef,
  parameter int SCORE_BITS = bss_pkg::ScoreBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [bss_pkg::NumBeamsW-1:0]         num_beams_i,
  input  logic signed [bss_pkg::LogProbW-1:0]   log_prob_i,
  input  logic [bss_pkg::BeamIndexW-1:0]        beam_index_i,
  input  logic                                  last_in_step_i,
  input  logic                                  last_in_sequence_i,
  input  bss_pkg::bss_cmd_t                     cmd_i,
  output bss_pkg::bss_stat_t                    stat_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [bss_pkg::FinalW-1:0]     final_score_o,
  output logic [bss_pkg::RankW-1:0]             score_rank_o,
  output logic                                  last_score_o
);

  // Only the beams that can ever be kept need storage.
  localparam int Keep = (MAX_BEAMS < bss_pkg::EmitLimit) ? MAX_BEAMS : bss_pkg::EmitLimit;
  localparam int IdxW = (Keep > 1) ? $clog2(Keep) : 1;
  localparam int CalcW = ((SCORE_BITS > bss_pkg::FinalW) ? SCORE_BITS : bss_pkg::FinalW) + 1;
  localparam int CntW = bss_pkg::NumBeamsW;

  localparam logic signed [SCORE_BITS-1:0] SMin  = {1'b1, {(SCORE_BITS-1){1'b0}}};
  localparam logic signed [SCORE_BITS-1:0] SMax  = {1'b0, {(SCORE_BITS-1){1'b1}}};
  localparam logic signed [SCORE_BITS-1:0] SMin1 = {1'b1, {(SCORE_BITS-2){1'b0}}, 1'b1};
  localparam logic signed [CalcW-1:0] SMaxW  = CalcW'(SMax);
  localparam logic signed [CalcW-1:0] SMin1W = CalcW'(SMin1);

  localparam logic signed [bss_pkg::FinalW-1:0] OMin =
    {1'b1, {(bss_pkg::FinalW-1){1'b0}}};
  localparam logic signed [bss_pkg::FinalW-1:0] OMax =
    {1'b0, {(bss_pkg::FinalW-1){1'b1}}};
  localparam logic signed [bss_pkg::FinalW-1:0] OMin1 =
    {1'b1, {(bss_pkg::FinalW-2){1'b0}}, 1'b1};
  localparam logic signed [CalcW-1:0] OMaxW  = CalcW'(OMax);
  localparam logic signed [CalcW-1:0] OMin1W = CalcW'(OMin1);

  logic signed [bss_pkg::LogProbW-1:0] lp_q;
  logic [bss_pkg::BeamIndexW-1:0]      idx_q;
  logic                                end_step_q, end_seq_q;
  logic signed [SCORE_BITS-1:0]        cand_q, cand_d;
  logic signed [SCORE_BITS-1:0]        beam_q [Keep];
  logic signed [SCORE_BITS-1:0]        best_q [Keep];
  logic signed [SCORE_BITS-1:0]        best_d [Keep];
  logic [bss_pkg::RankW-1:0]           cnt_q;
  logic                                out_valid_q;
  logic signed [bss_pkg::FinalW-1:0]   final_q, final_d;
  logic [bss_pkg::RankW-1:0]           rank_q;
  logic                                last_q;

  logic [CntW-1:0]                     k_eff;
  logic                                emit_last;
  logic signed [SCORE_BITS-1:0]        base;
  logic signed [CalcW-1:0]             x_ext, x_cl, sum_w, sum_cl, s_ext, o_cl;
  logic                                in_min;
  logic [Keep-1:0]                     lt;
  logic signed [SCORE_BITS-1:0]        emit_score;

  // Effective beam count: zero acts as one, capped by the store depth.
  always_comb begin
    if (num_beams_i == '0) k_eff = CntW'(1);
    else if (num_beams_i > CntW'(Keep)) k_eff = CntW'(Keep);
    else k_eff = num_beams_i;
  end

  // Candidate score: beam score plus log probability, saturating, with the
  // minimum code acting as a sticky minus infinity.
  always_comb begin
    if (CntW'(idx_q) < CntW'(Keep)) base = beam_q[idx_q[IdxW-1:0]];
    else base = SMin;
    in_min = (lp_q == OMin);
    x_ext  = CalcW'(lp_q);
    if (x_ext > SMaxW) x_cl = SMaxW;
    else if (x_ext < SMin1W) x_cl = SMin1W;
    else x_cl = x_ext;
    sum_w = CalcW'(base) + x_cl;
    if (sum_w > SMaxW) sum_cl = SMaxW;
    else if (sum_w < SMin1W) sum_cl = SMin1W;
    else sum_cl = sum_w;
    if (in_min || base == SMin) cand_d = SMin;
    else cand_d = SCORE_BITS'(sum_cl);
  end

  // Sorted insertion: every kept entry below the candidate moves down one place.
  always_comb begin
    for (int i = 0; i < Keep; i++) begin
      lt[i] = (CntW'(i) < k_eff) && (best_q[i] < cand_q);
    end
    for (int i = 0; i < Keep; i++) begin
      if (!lt[i]) best_d[i] = best_q[i];
      else if (i > 0 && lt[(i > 0) ? i - 1 : 0]) best_d[i] = best_q[(i > 0) ? i - 1 : 0];
      else best_d[i] = cand_q;
    end
  end

  // Result conversion to the 32-bit output code.
  always_comb begin
    emit_score = beam_q[cnt_q[IdxW-1:0]];
    s_ext      = CalcW'(emit_score);
    if (s_ext > OMaxW) o_cl = OMaxW;
    else if (s_ext < OMin1W) o_cl = OMin1W;
    else o_cl = s_ext;
    if (emit_score == SMin) final_d = OMin;
    else final_d = bss_pkg::FinalW'(o_cl);
  end

  assign emit_last = ((CntW'(cnt_q) + CntW'(1)) == k_eff);

  // Input capture and candidate register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lp_q       <= log_prob_i;
      idx_q      <= beam_index_i;
      end_step_q <= last_in_step_i;
      end_seq_q  <= last_in_sequence_i;
    end
    if (cmd_i.calc) begin
      cand_q <= cand_d;
    end
  end

  // Beam scores and candidate list.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Keep; i++) begin
        beam_q[i] <= (i == 0) ? '0 : SMin;
        best_q[i] <= SMin;
      end
    end else if (cmd_i.insert) begin
      for (int i = 0; i < Keep; i++) best_q[i] <= best_d[i];
    end else if (cmd_i.commit) begin
      for (int i = 0; i < Keep; i++) begin
        beam_q[i] <= (CntW'(i) < k_eff) ? best_q[i] : SMin;
        best_q[i] <= SMin;
      end
    end else if (cmd_i.clear) begin
      for (int i = 0; i < Keep; i++) beam_q[i] <= (i == 0) ? '0 : SMin;
    end
  end

  // Emission counter and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) cnt_q <= '0;
      else if (cmd_i.emit) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      final_q <= final_d;
      rank_q  <= cnt_q;
      last_q  <= emit_last;
    end
  end

  assign stat_o.end_step  = end_step_q;
  assign stat_o.end_seq   = end_seq_q;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign stat_o.emit_last = emit_last;

  assign out_valid_o   = out_valid_q;
  assign final_score_o = final_q;
  assign score_rank_o  = rank_q;
  assign last_score_o  = last_q;

  // The candidate list stays sorted best first.
  for (genvar g = 0; g + 1 < Keep; g++) begin : g_sorted
    a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
      best_q[g] >= best_q[g+1])
      else $error("candidate list out of order");
  end

  // Closing a step empties the candidate list.
  a_commit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> best_q[0] == SMin)
    else $error("candidate list not cleared at step end");

  // The end of a run restores beam zero to a live zero score.
  a_clear_beam0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> beam_q[0] == '0)
    else $error("beam zero not restored after emission");

  // A result is loaded only when the result register can take it.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

endmodule

>>> rtl/beam_search_score_topk.sv
// Beam search score selector top level; depends on bss_pkg, bss_if, bss_ctrl, bss_datapath.
// A sequence end transfer passes the add, insert and commit states; the emit state then
// loads one result per cycle while the sink takes them. The one shared adder and insertion
// chain takes items one at a time: each passes add and insert, a step end also commit,
// a sequence end also emit. Reset (asynchronous, active low) sets beam zero to zero, all
// other scores and candidates to minus infinity, and num_beams to 4.
`timescale 1ns / 1ps

module beam_search_score_topk #(
  parameter int MAX_BEAMS  = bss_pkg::MaxBeamsDef,
  parameter int SCORE_BITS = bss_pkg::ScoreBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bss_in_if.sink                        in_if,
  bss_out_if.source                     out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bss_pkg::ApbAddrW-1:0]  paddr,
  input  logic [bss_pkg::ApbDataW-1:0]  pwdata,
  output logic [bss_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);

  logic [bss_pkg::NumBeamsW-1:0] num_beams_q;
  logic                          reg_sel;
  logic                          in_ready;
  bss_pkg::bss_cmd_t             cmd;
  bss_pkg::bss_stat_t            stat;

  // Configuration register: written on the access phase of an APB transfer.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[bss_pkg::ApbAddrW-1:bss_pkg::RegIdxLsb] == bss_pkg::RegNumBeams);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_beams_q <= bss_pkg::NumBeamsRst;
    end else if (psel && penable && pwrite && reg_sel) begin
      num_beams_q <= pwdata[bss_pkg::NumBeamsW-1:0];
    end
  end

  assign prdata = reg_sel ? bss_pkg::ApbDataW'(num_beams_q) : '0;

  assign in_if.ready = in_ready;

  bss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bss_datapath #(
    .MAX_BEAMS  (MAX_BEAMS),
    .SCORE_BITS (SCORE_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .num_beams_i        (num_beams_q),
    .log_prob_i         (in_if.log_prob),
    .beam_index_i       (in_if.beam_index),
    .last_in_step_i     (in_if.last_in_step),
    .last_in_sequence_i (in_if.last_in_sequence),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .out_valid_o        (out_if.valid),
    .out_ready_i        (out_if.ready),
    .final_score_o      (out_if.final_score),
    .score_rank_o       (out_if.score_rank),
    .last_score_o       (out_if.last_score)
  );

endmodule

>>> test/beam_score_checker.sv
// Checker for the beam search score selector: watches the item channels and the
// register port, predicts the emitted final scores and compares every result.
// Depends on bss_pkg and bss_if.
`timescale 1ns / 1ps

module beam_score_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bss_in_if                             in_mon,
  bss_out_if                            out_mon,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic                          pready_i,
  input  logic [bss_pkg::ApbAddrW-1:0]  paddr_i,
  input  logic [bss_pkg::ApbDataW-1:0]  pwdata_i,
  output int                            fail_count_o,
  output int                            backlog_o
);

  localparam logic signed [bss_pkg::FinalW-1:0] MinusInf =
    {1'b1, {(bss_pkg::FinalW-1){1'b0}}};
  localparam logic signed [bss_pkg::FinalW-1:0] ScoreCeil = ~MinusInf;

  typedef struct packed {
    logic [bss_pkg::FinalW-1:0] score;
    logic [bss_pkg::RankW-1:0]  rank;
    logic                       last;
  } final_score_t;

  logic [bss_pkg::NumBeamsW-1:0]     beams_cfg;
  logic signed [bss_pkg::FinalW-1:0] beam_score [bss_pkg::MaxBeamsDef];
  logic signed [bss_pkg::FinalW-1:0] ranked_cand [bss_pkg::MaxBeamsDef];
  final_score_t                      final_scores_q [$];
  int                                fail_count;

  // Beams actually kept for a given register value.
  function automatic int kept_beams(logic [bss_pkg::NumBeamsW-1:0] n);
    int k;
    k = int'(n);
    if (k == 0) k = 1;
    if (k > bss_pkg::MaxBeamsDef) k = bss_pkg::MaxBeamsDef;
    if (k > bss_pkg::EmitLimit) k = bss_pkg::EmitLimit;
    return k;
  endfunction

  // Saturating sum; minus infinity on either side is sticky, and a finite sum
  // never lands on minus infinity.
  function automatic logic signed [bss_pkg::FinalW-1:0] extend_score(
    logic signed [bss_pkg::FinalW-1:0] base,
    logic signed [bss_pkg::LogProbW-1:0] lp
  );
    longint s;
    if (base == MinusInf || lp == MinusInf) return MinusInf;
    s = longint'(base) + longint'(lp);
    if (s > longint'(ScoreCeil)) return ScoreCeil;
    if (s <= longint'(MinusInf)) return MinusInf + 1;
    return s[bss_pkg::FinalW-1:0];
  endfunction

  // Insert into the descending candidate list; the weakest entry drops out.
  function automatic void rank_candidate(logic signed [bss_pkg::FinalW-1:0] c, int k);
    int pos;
    pos = 0;
    while (pos < k && ranked_cand[pos] >= c) pos++;
    if (pos < k) begin
      for (int j = k - 1; j > pos; j--) ranked_cand[j] = ranked_cand[j-1];
      ranked_cand[pos] = c;
    end
  endfunction

  function automatic void clear_scores();
    for (int i = 0; i < bss_pkg::MaxBeamsDef; i++) begin
      beam_score[i] = MinusInf;
      ranked_cand[i] = MinusInf;
    end
    beam_score[0] = '0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : score_model
    final_score_t                      got;
    final_score_t                      want;
    int                                k;
    logic signed [bss_pkg::FinalW-1:0] cand;
    if (!rst_ni) begin
      beams_cfg = bss_pkg::NumBeamsRst;
      clear_scores();
      final_scores_q.delete();
      fail_count = 0;
    end else begin
      // Each item transfer extends one beam and may close a step or a sequence.
      if (in_mon.valid && in_mon.ready) begin
        k = kept_beams(beams_cfg);
        cand = extend_score(beam_score[in_mon.beam_index], in_mon.log_prob);
        rank_candidate(cand, k);
        if (in_mon.last_in_step || in_mon.last_in_sequence) begin
          for (int i = 0; i < bss_pkg::MaxBeamsDef; i++) begin
            beam_score[i] = (i < k) ? ranked_cand[i] : MinusInf;
            ranked_cand[i] = MinusInf;
          end
        end
        if (in_mon.last_in_sequence) begin
          for (int i = 0; i < k; i++) begin
            want.score = beam_score[i];
            want.rank = bss_pkg::RankW'(i);
            want.last = (i == k - 1);
            final_scores_q.push_back(want);
          end
          clear_scores();
        end
      end

      // Register writes must come only while the block is idle; the block does not enforce it.
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i[bss_pkg::ApbAddrW-1:bss_pkg::RegIdxLsb] == bss_pkg::RegNumBeams) begin
        beams_cfg = pwdata_i[bss_pkg::NumBeamsW-1:0];
      end

      // Every result transfer must match the oldest predicted score.
      if (out_mon.valid && out_mon.ready) begin
        got.score = out_mon.final_score;
        got.rank = out_mon.score_rank;
        got.last = out_mon.last_score;
        if (final_scores_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected result: score %0d rank %0d last %0b",
                     $signed(got.score), got.rank, got.last);
          end
        end else begin
          want = final_scores_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result mismatch: expected score %0d rank %0d last %0b",
                       $signed(want.score), want.rank, want.last);
              $display("                 got      score %0d rank %0d last %0b",
                       $signed(got.score), got.rank, got.last);
            end
          end
        end
      end
    end
    fail_count_o <= fail_count;
    backlog_o <= final_scores_q.size();
  end

endmodule

>>> test/testbench.sv
// Top of the beam search score selector test: clock, reset, register writes,
// item stimulus, result-side stalls, watchdog and verdict.
// Depends on bss_pkg, bss_if, beam_search_score_topk and beam_score_checker.
`timescale 1ns / 1ps

module testbench;

  localparam int IdleMax       = 13;
  localparam int DrainCycles   = 8;
  localparam int HoldCycles    = 300;
  localparam int WatchdogLimit = 2000;
  localparam int PhaseItems    = 65;
  localparam int NumPhases     = 6;

  localparam logic [bss_pkg::ApbAddrW-1:0] NumBeamsAddr =
    bss_pkg::ApbAddrW'(bss_pkg::RegNumBeams) << bss_pkg::RegIdxLsb;
  localparam logic signed [bss_pkg::LogProbW-1:0] LogMinusInf =
    {1'b1, {(bss_pkg::LogProbW-1){1'b0}}};
  localparam logic signed [bss_pkg::LogProbW-1:0] LogCeil = ~LogMinusInf;
  localparam logic signed [bss_pkg::LogProbW-1:0] OneQ = 32'sh0001_0000;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic                         pready;
  logic [bss_pkg::ApbAddrW-1:0] paddr;
  logic [bss_pkg::ApbDataW-1:0] pwdata;
  logic [bss_pkg::ApbDataW-1:0] prdata;
  int                           fail_count;
  int                           backlog;
  int                           items_sent = 0;
  int                           kept;
  bit                           send_burst = 1'b0;
  bit                           hold_request = 1'b0;

  bss_in_if  in_bus ();
  bss_out_if out_bus ();

  beam_search_score_topk u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_bus),
    .out_if  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  beam_score_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_bus),
    .out_mon      (out_bus),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .backlog_o    (backlog)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // One item transfer, after a random gap unless the sender runs in a burst.
  task automatic send_item(input logic signed [bss_pkg::LogProbW-1:0] lp,
                           input logic [bss_pkg::BeamIndexW-1:0] idx,
                           input bit step_end, input bit seq_end);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, IdleMax);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.log_prob <= lp;
    in_bus.beam_index <= idx;
    in_bus.last_in_step <= step_end;
    in_bus.last_in_sequence <= seq_end;
    do @(posedge clk_i); while (!(in_bus.valid && in_bus.ready));
    items_sent++;
  endtask

  // Stop offering items and wait until every predicted score has arrived,
  // then let the block finish any item still in flight.
  task automatic wait_all_scores();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (backlog != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Result side: random stalls, calm stretches, and one long hold on request.
  initial begin
    int wait_cycles;
    int calm_left;
    out_bus.ready <= 1'b0;
    calm_left = 0;
    @(posedge rst_ni);
    forever begin
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 5) == 0) calm_left = $urandom_range(10, 30);
      wait_cycles = (calm_left > 0) ? 0 : $urandom_range(0, IdleMax);
      if (hold_request) begin
        hold_request = 1'b0;
        wait_cycles = HoldCycles;
      end
      if (wait_cycles > 0) begin
        out_bus.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_bus.valid && out_bus.ready));
    end
  end

  // Watchdog: too long without any transfer on either channel ends the run.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [bss_pkg::NumBeamsW-1:0]        beam_counts [NumPhases];
    logic [bss_pkg::BeamIndexW-1:0]       idx;
    logic signed [bss_pkg::LogProbW-1:0]  lp;
    bit                                   step_end;
    int                                   steps;
    int                                   tokens;
    int                                   flavor;
    int                                   n;
    int                                   phase_start;

    rst_ni <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.log_prob <= '0;
    in_bus.beam_index <= '0;
    in_bus.last_in_step <= 1'b0;
    in_bus.last_in_sequence <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    kept = int'(bss_pkg::NumBeamsRst);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset beam count of four.
    // Lone item: beam zero starts at zero, the others stay at minus infinity.
    send_item('0, bss_pkg::BeamIndexW'(0), 1'b0, 1'b1);
    // Minus infinity in; one item closes both the step and the sequence.
    send_item(LogMinusInf, bss_pkg::BeamIndexW'(0), 1'b1, 1'b1);
    // Positive saturation over two steps; the sequence ends without a step end.
    send_item(LogCeil, bss_pkg::BeamIndexW'(0), 1'b1, 1'b0);
    send_item(LogCeil, bss_pkg::BeamIndexW'(0), 1'b0, 1'b1);
    // Negative saturation stops one code above minus infinity.
    send_item(LogMinusInf + 1, bss_pkg::BeamIndexW'(0), 1'b1, 1'b0);
    send_item(LogMinusInf + 1, bss_pkg::BeamIndexW'(0), 1'b0, 1'b1);
    // A beam outside the kept ones reads as minus infinity.
    send_item(OneQ, bss_pkg::BeamIndexW'(15), 1'b0, 1'b1);
    // Short step with tied candidates.
    send_item(-OneQ, bss_pkg::BeamIndexW'(0), 1'b0, 1'b0);
    send_item(-OneQ, bss_pkg::BeamIndexW'(0), 1'b0, 1'b0);
    send_item(-2 * OneQ, bss_pkg::BeamIndexW'(0), 1'b1, 1'b0);
    // More candidates than beams, one of them on a dead beam.
    send_item(-OneQ / 2, bss_pkg::BeamIndexW'(0), 1'b0, 1'b0);
    send_item(-OneQ / 2, bss_pkg::BeamIndexW'(1), 1'b0, 1'b0);
    send_item(OneQ / 4, bss_pkg::BeamIndexW'(2), 1'b0, 1'b0);
    send_item(2 * OneQ, bss_pkg::BeamIndexW'(3), 1'b0, 1'b0);
    send_item(-3 * OneQ, bss_pkg::BeamIndexW'(1), 1'b0, 1'b0);
    send_item('0, bss_pkg::BeamIndexW'(0), 1'b1, 1'b0);
    send_item(LogMinusInf, bss_pkg::BeamIndexW'(2), 1'b0, 1'b1);

    // Random part: one beam count per phase, extremes included.
    beam_counts = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd9,
                    bss_pkg::NumBeamsW'($urandom_range(0, 31))};
    for (int p = 0; p < NumPhases; p++) begin
      wait_all_scores();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= NumBeamsAddr;
      pwdata <= bss_pkg::ApbDataW'(beam_counts[p]);
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      kept = (beam_counts[p] == 0) ? 1 :
             (int'(beam_counts[p]) > bss_pkg::EmitLimit) ? bss_pkg::EmitLimit :
             int'(beam_counts[p]);
      // With all sixteen beams kept, stall the result side for a long stretch.
      if (p == 1) hold_request = 1'b1;

      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) begin
        steps = (kept > 8) ? $urandom_range(1, 2) : $urandom_range(1, 4);
        tokens = (kept > 8) ? 1 : $urandom_range(1, 3);
        // Mostly well-formed sequences; some noise and some cut short.
        flavor = $urandom_range(0, 9);
        send_burst = ($urandom_range(0, 3) == 0);
        for (int s = 0; s < steps; s++) begin
          n = kept * tokens;
          if (flavor == 1 && s == steps - 1) n = $urandom_range(1, n);
          for (int j = 0; j < n; j++) begin
            case ($urandom_range(0, 19))
              0:       lp = LogMinusInf;
              1:       lp = LogCeil;
              2:       lp = LogMinusInf + 1;
              3, 4:    lp = $urandom;
              5, 6:    lp = -OneQ * $urandom_range(0, 3);
              7:       lp = $urandom_range(0, 4 * 65536);
              default: lp = -int'($urandom_range(0, 12 * 65536));
            endcase
            if (flavor == 0 || $urandom_range(0, 19) == 0) begin
              idx = bss_pkg::BeamIndexW'($urandom_range(0, 15));
            end else begin
              idx = bss_pkg::BeamIndexW'(j % kept);
            end
            step_end = (j == n - 1) && !(flavor == 1 && s == steps - 1);
            if (flavor == 0 && $urandom_range(0, 5) == 0) step_end = 1'b1;
            send_item(lp, idx, step_end, (s == steps - 1) && (j == n - 1));
          end
        end
      end
    end

    wait_all_scores();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
